@@ rtl/lsdc_pkg.sv @@
package lsdc_pkg;

  // Fixed point fraction bits of all lengths (1/256 pixel).
  localparam int FRAC_BITS = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int COORD_W    = 24;
  localparam int HW_W       = 20;
  localparam int PIX_W      = 16;
  localparam int DIST_W     = 26;
  localparam int COV_W      = 9;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_START_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 3'd4;

  // Datapath widths.
  localparam int POS_W  = PIX_W + FRAC_BITS;      // pixel position, unsigned
  localparam int DIFF_W = POS_W + 2;              // pixel minus endpoint, signed
  localparam int SEG_W  = COORD_W + 1;            // segment vector, signed
  localparam int PROD_W = DIFF_W + SEG_W;         // dot and cross products
  localparam int SUM_W  = PROD_W + 1;             // dot and cross sums
  localparam int SQ_W   = 2 * (DIFF_W - 1);       // one squared difference
  localparam int PNT_W  = SQ_W + 1;               // squared point distance
  localparam int LL_W   = SQ_W;                   // squared segment length
  localparam int CR_W   = SQ_W;                   // magnitude of the cross product
  localparam int CRH_W  = CR_W / 2;               // half of the cross product
  localparam int NUM_W  = 2 * CR_W;               // dividend
  localparam int QB     = 2 * DIST_W;             // quotient bits
  localparam int SQ_STEPS = DIST_W;               // root bits
  localparam int RR_W   = QB + 1;                 // root remainder
  localparam int EDGE_W = HW_W + 1;
  localparam int ONE    = 1 << FRAC_BITS;
  localparam logic [COV_W-1:0] COV_FULL = COV_W'(256);

endpackage

@@ rtl/lsdc_if.sv @@
interface lsdc_in_if import lsdc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface lsdc_out_if import lsdc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              inside_res;
  logic [COV_W-1:0]  coverage;

  modport source (output valid, output distance, output inside_res, output coverage,
                  input ready);
  modport sink   (input valid, input distance, input inside_res, input coverage,
                  output ready);
endinterface

@@ rtl/line_segment_distance_coverage.sv @@
// Distance from a pixel to one line segment, with a hard inside flag and an
// anti-aliased coverage value.
// The segment and the stroke width are set through the write port
// (cfg_we, cfg_index, cfg_data) while no item is in flight; writes to an
// unknown index are dropped. All lengths are in 1/256 pixel.
// Each item on in_item carries a pixel column and row; for every item one
// result leaves on out_item with the distance (floor of the exact value),
// inside_res and coverage (256 means fully covered).
// Throughput is one item per cycle while out_item is not stalled. An item
// passes 84 register stages: four for differences, products, sums with
// selection and the cross square, 53 in a one-bit-per-stage restoring divider,
// 26 in a one-bit-per-stage square root, then the coverage output register.
// When the receiver stalls the whole pipeline holds and in_item.ready drops;
// no item is lost or repeated. Reset clears the configuration registers and
// the valid bits, which empties the pipeline.
module line_segment_distance_coverage
  import lsdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  lsdc_in_if.sink               in_item,
  lsdc_out_if.source            out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic signed [COORD_W-1:0] start_x_r, start_y_r, end_x_r, end_y_r;
  logic [HW_W-1:0]           half_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
      end_x_r   <= '0;
      end_y_r   <= '0;
      half_w_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_X:    start_x_r <= cfg_data;
        REG_START_Y:    start_y_r <= cfg_data;
        REG_END_X:      end_x_r   <= cfg_data;
        REG_END_Y:      end_y_r   <= cfg_data;
        REG_HALF_WIDTH: half_w_r  <= cfg_data[HW_W-1:0];
        default: ;
      endcase
    end
  end

  logic stall, adv;
  logic out_vld_r;
  assign stall = out_vld_r && !out_item.ready;
  assign adv   = !stall;
  assign in_item.ready = adv;

  // Stage 1: differences.
  logic signed [DIFF_W-1:0] px, py;
  logic signed [DIFF_W-1:0] s1_ax_r, s1_ay_r, s1_bx_r, s1_by_r;
  logic signed [SEG_W-1:0]  s1_sx_r, s1_sy_r;
  logic                     s1_vld_r;

  assign px = DIFF_W'({in_item.pixel_x, FRAC_BITS'(0)});
  assign py = DIFF_W'({in_item.pixel_y, FRAC_BITS'(0)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ax_r <= px - DIFF_W'(start_x_r);
      s1_ay_r <= py - DIFF_W'(start_y_r);
      s1_bx_r <= px - DIFF_W'(end_x_r);
      s1_by_r <= py - DIFF_W'(end_y_r);
      s1_sx_r <= SEG_W'(end_x_r) - SEG_W'(start_x_r);
      s1_sy_r <= SEG_W'(end_y_r) - SEG_W'(start_y_r);
    end
  end

  // Stage 2: products.
  logic signed [PROD_W-1:0] m_dx, m_dy, m_ca, m_cb;
  logic signed [2*SEG_W-1:0] m_sx, m_sy;
  logic signed [2*DIFF_W-1:0] m_ax, m_ay, m_bx, m_by;

  assign m_dx = PROD_W'(s1_ax_r) * PROD_W'(s1_sx_r);
  assign m_dy = PROD_W'(s1_ay_r) * PROD_W'(s1_sy_r);
  assign m_ca = PROD_W'(s1_ax_r) * PROD_W'(s1_sy_r);
  assign m_cb = PROD_W'(s1_ay_r) * PROD_W'(s1_sx_r);
  assign m_sx = (2*SEG_W)'(s1_sx_r) * (2*SEG_W)'(s1_sx_r);
  assign m_sy = (2*SEG_W)'(s1_sy_r) * (2*SEG_W)'(s1_sy_r);
  assign m_ax = (2*DIFF_W)'(s1_ax_r) * (2*DIFF_W)'(s1_ax_r);
  assign m_ay = (2*DIFF_W)'(s1_ay_r) * (2*DIFF_W)'(s1_ay_r);
  assign m_bx = (2*DIFF_W)'(s1_bx_r) * (2*DIFF_W)'(s1_bx_r);
  assign m_by = (2*DIFF_W)'(s1_by_r) * (2*DIFF_W)'(s1_by_r);

  logic signed [PROD_W-1:0] s2_dx_r, s2_dy_r, s2_ca_r, s2_cb_r;
  logic [LL_W-1:0]          s2_sx_r, s2_sy_r;
  logic [SQ_W-1:0]          s2_ax_r, s2_ay_r, s2_bx_r, s2_by_r;
  logic                     s2_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_dx_r <= m_dx;
      s2_dy_r <= m_dy;
      s2_ca_r <= m_ca;
      s2_cb_r <= m_cb;
      s2_sx_r <= m_sx[LL_W-1:0];
      s2_sy_r <= m_sy[LL_W-1:0];
      s2_ax_r <= m_ax[SQ_W-1:0];
      s2_ay_r <= m_ay[SQ_W-1:0];
      s2_bx_r <= m_bx[SQ_W-1:0];
      s2_by_r <= m_by[SQ_W-1:0];
    end
  end

  // Stage 3: sums and the choice between endpoint and perpendicular distance.
  logic signed [SUM_W-1:0] dot, cross_s;
  logic [LL_W-1:0]         len2;
  logic [SUM_W-1:0]        cross_mag;
  logic                    before_start, past_end, perp;

  assign dot       = SUM_W'(s2_dx_r) + SUM_W'(s2_dy_r);
  assign cross_s   = SUM_W'(s2_ca_r) - SUM_W'(s2_cb_r);
  assign len2      = s2_sx_r + s2_sy_r;
  assign cross_mag = cross_s[SUM_W-1] ? SUM_W'(-cross_s) : SUM_W'(cross_s);
  assign before_start = dot[SUM_W-1];
  assign past_end  = !before_start && ($unsigned(dot) > SUM_W'(len2));
  assign perp      = (len2 != '0) && !before_start && !past_end;

  logic [PNT_W-1:0] s3_pnum_r;
  logic [CR_W-1:0]  s3_cr_r;
  logic [LL_W-1:0]  s3_den_r;
  logic             s3_perp_r, s3_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_pnum_r <= past_end && (len2 != '0) ? PNT_W'(s2_bx_r) + PNT_W'(s2_by_r)
                                            : PNT_W'(s2_ax_r) + PNT_W'(s2_ay_r);
      s3_cr_r   <= cross_mag[CR_W-1:0];
      s3_den_r  <= perp ? len2 : LL_W'(1);
      s3_perp_r <= perp;
    end
  end

  // Stage 4: square of the cross product as three partial products.
  logic [CRH_W-1:0] cr_hi, cr_lo;
  assign cr_hi = s3_cr_r[CR_W-1:CRH_W];
  assign cr_lo = s3_cr_r[CRH_W-1:0];

  logic [2*CRH_W-1:0] s4_hh_r, s4_hl_r, s4_ll_r;
  logic [PNT_W-1:0]   s4_pnum_r;
  logic [LL_W-1:0]    s4_den_r;
  logic               s4_perp_r, s4_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_hh_r   <= cr_hi * cr_hi;
      s4_hl_r   <= cr_hi * cr_lo;
      s4_ll_r   <= cr_lo * cr_lo;
      s4_pnum_r <= s3_pnum_r;
      s4_den_r  <= s3_den_r;
      s4_perp_r <= s3_perp_r;
    end
  end

  logic [NUM_W-1:0] num;
  assign num = s4_perp_r ? (NUM_W'(s4_hh_r) << (2*CRH_W)) + (NUM_W'(s4_hl_r) << (CRH_W+1))
                           + NUM_W'(s4_ll_r)
                         : NUM_W'(s4_pnum_r);

  // Restoring divider, one quotient bit per stage. The quotient bits shift
  // into the low end of the word as the dividend bits leave its top.
  logic [LL_W-1:0] div_rem_r [QB+1];
  logic [QB-1:0]   div_w_r   [QB+1];
  logic [LL_W-1:0] div_den_r [QB+1];
  logic            div_vld_r [QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_vld_r[0] <= 1'b0;
    end else if (adv) begin
      div_vld_r[0] <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_rem_r[0] <= LL_W'(num[NUM_W-1:QB]);
      div_w_r[0]   <= num[QB-1:0];
      div_den_r[0] <= s4_den_r;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_div
    logic [LL_W:0] trial;
    logic          take;
    assign trial = {div_rem_r[i], div_w_r[i][QB-1]};
    assign take  = trial >= (LL_W+1)'(div_den_r[i]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        div_vld_r[i+1] <= div_vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_rem_r[i+1] <= take ? LL_W'(trial - (LL_W+1)'(div_den_r[i])) : LL_W'(trial);
        div_w_r[i+1]   <= {div_w_r[i][QB-2:0], take};
        div_den_r[i+1] <= div_den_r[i];
      end
    end
  end

  // Square root, one root bit per stage, keeping quotient minus root squared.
  logic [RR_W-1:0]   sq_rem_r  [SQ_STEPS+1];
  logic [DIST_W-1:0] sq_root_r [SQ_STEPS+1];
  logic              sq_vld_r  [SQ_STEPS+1];

  assign sq_rem_r[0]  = RR_W'(div_w_r[QB]);
  assign sq_root_r[0] = '0;
  assign sq_vld_r[0]  = div_vld_r[QB];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam int B = SQ_STEPS - 1 - j;
    logic [RR_W:0] cand;
    logic          take;
    assign cand = ((RR_W+1)'(sq_root_r[j]) << (B+1)) + ((RR_W+1)'(1) << (2*B));
    assign take = cand <= (RR_W+1)'(sq_rem_r[j]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[j+1] <= 1'b0;
      end else if (adv) begin
        sq_vld_r[j+1] <= sq_vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem_r[j+1]  <= take ? RR_W'((RR_W+1)'(sq_rem_r[j]) - cand) : sq_rem_r[j];
        sq_root_r[j+1] <= take ? (sq_root_r[j] | (DIST_W'(1) << B)) : sq_root_r[j];
      end
    end
  end

  // Output stage: inside flag and coverage.
  logic [DIST_W-1:0]           seg_dist;
  logic [EDGE_W-1:0]           edge_d;
  logic signed [DIST_W+1:0]    over;
  logic [FRAC_BITS:0]          cov_fb;
  logic [COV_W-1:0]            cov;

  assign seg_dist = sq_root_r[SQ_STEPS];
  assign edge_d   = EDGE_W'(half_w_r) + EDGE_W'(ONE / 2);
  assign over     = (DIST_W+2)'(seg_dist) - (DIST_W+2)'(edge_d);

  always_comb begin
    if (over <= 0) begin
      cov_fb = (FRAC_BITS+1)'(ONE);
    end else if (over >= (DIST_W+2)'(ONE)) begin
      cov_fb = '0;
    end else begin
      cov_fb = (FRAC_BITS+1)'(ONE) - (FRAC_BITS+1)'(over);
    end
  end

  if (FRAC_BITS >= 8) begin : g_scale_dn
    assign cov = COV_W'(cov_fb >> (FRAC_BITS - 8));
  end else begin : g_scale_up
    assign cov = COV_W'(cov_fb) << (8 - FRAC_BITS);
  end

  logic [DIST_W-1:0] out_dist_r;
  logic              out_inside_r;
  logic [COV_W-1:0]  out_cov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= sq_vld_r[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_dist_r   <= seg_dist;
      out_inside_r <= (DIST_W+1)'(seg_dist) < (DIST_W+1)'(edge_d);
      out_cov_r    <= cov;
    end
  end

  assign out_item.valid      = out_vld_r;
  assign out_item.distance   = out_dist_r;
  assign out_item.inside_res = out_inside_r;
  assign out_item.coverage   = out_cov_r;

`ifndef ASSERT_OFF
  // A stall freezes the items inside the pipeline.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> $stable(s4_vld_r) && $stable(div_vld_r[QB]) && $stable(sq_vld_r[SQ_STEPS]))
    else $error("pipeline moved during a stall");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    div_vld_r[QB] |-> div_rem_r[QB] < div_den_r[QB])
    else $error("divider remainder not below divisor");

  a_perp_den: assert property (@(posedge clk) disable iff (!rst_n)
    s4_vld_r && s4_perp_r |-> s4_den_r != '0)
    else $error("perpendicular case with zero length");

  a_inside_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_inside_r |-> out_cov_r == COV_FULL)
    else $error("inside pixel without full coverage");

  a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_cov_r == '0 |-> !out_inside_r)
    else $error("uncovered pixel flagged inside");
`endif

endmodule

@@ verif/line_segment_distance_coverage_tb.sv @@
`timescale 1ns / 100ps

module line_segment_distance_coverage_tb;
  import lsdc_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              inside_res;
    logic [COV_W-1:0]  coverage;
  } pixel_shade_t;

  localparam int PIPE_LATENCY = 84;
  localparam int CYCLE_LIMIT  = 1500000;
  // An index that maps to no register.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lsdc_in_if  in_item ();
  lsdc_out_if out_item ();

  line_segment_distance_coverage DUT (
    .clk(clk), .rst_n(rst_n), .in_item(in_item.sink), .out_item(out_item.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow copy of the segment registers used by the predictor.
  logic signed [COORD_W-1:0] seg_ax, seg_ay, seg_bx, seg_by;
  logic [HW_W-1:0] seg_half_w;

  pixel_shade_t shade_queue[$];
  int err_count;
  longint cycle_count;
  int send_idle_pct, recv_stall_pct;

  initial begin
    in_item.valid = 1'b0;
    in_item.pixel_x = '0;
    in_item.pixel_y = '0;
    out_item.ready = 1'b0;
  end

  function automatic logic [127:0] mag_of(input longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  // Largest d below 2^26 with d*d*den <= num.
  function automatic longint unsigned floor_root_div(input logic [127:0] num,
                                                     input logic [127:0] den);
    logic [127:0] d;
    logic [127:0] c;
    d = '0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      c = d | (128'd1 << b);
      if (c * c * den <= num) d = c;
    end
    return longint'(d);
  endfunction

  function automatic pixel_shade_t shade_pixel(input logic [PIX_W-1:0] x,
                                               input logic [PIX_W-1:0] y);
    pixel_shade_t r;
    longint px, py, ax, ay, bx, by, sx, sy, dot, t, edge_w, cov;
    logic [127:0] ll, cr;
    longint unsigned dist_q;
    px = longint'(x) <<< FRAC_BITS;
    py = longint'(y) <<< FRAC_BITS;
    ax = seg_ax; ay = seg_ay; bx = seg_bx; by = seg_by;
    sx = bx - ax; sy = by - ay;
    ll = 128'(sx * sx) + 128'(sy * sy);
    dot = (px - ax) * sx + (py - ay) * sy;
    if (ll == 0 || dot < 0)
      dist_q = floor_root_div(mag_of(px - ax) ** 2 + mag_of(py - ay) ** 2, 128'd1);
    else if (128'(dot) > ll)
      dist_q = floor_root_div(mag_of(px - bx) ** 2 + mag_of(py - by) ** 2, 128'd1);
    else begin
      cr = mag_of((ay - py) * sx - (ax - px) * sy);
      dist_q = floor_root_div(cr * cr, ll);
    end
    edge_w = longint'(seg_half_w) + (ONE >> 1);
    t = longint'(dist_q) - edge_w;
    if (t <= 0) cov = ONE;
    else if (t >= ONE) cov = 0;
    else cov = ONE - t;
    r.distance = DIST_W'(dist_q);
    r.inside_res = longint'(dist_q) < edge_w;
    r.coverage = COV_W'(cov >>> (FRAC_BITS - 8));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    err_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_START_X:    seg_ax = val;
      REG_START_Y:    seg_ay = val;
      REG_END_X:      seg_bx = val;
      REG_END_Y:      seg_by = val;
      REG_HALF_WIDTH: seg_half_w = val[HW_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_item.valid <= 1'b0;
    while (shade_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_segment(input int ax, input int ay, input int bx, input int by,
                             input int hw);
    wait_drained();
    write_reg(REG_START_X, ax[23:0]);
    write_reg(REG_START_Y, ay[23:0]);
    write_reg(REG_END_X, bx[23:0]);
    write_reg(REG_END_Y, by[23:0]);
    write_reg(REG_HALF_WIDTH, hw[23:0]);
  endtask

  // Leaves valid high after the accepting edge; the next idle cycle or the
  // drain drops it.
  task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_item.valid <= 1'b0;
      @(posedge clk);
    end
    in_item.valid <= 1'b1;
    in_item.pixel_x <= x;
    in_item.pixel_y <= y;
    @(posedge clk);
    while (!in_item.ready) @(posedge clk);
    shade_queue.push_back(shade_pixel(x, y));
  endtask

  // Pixels mostly near the segment so that coverage edges are exercised.
  task automatic send_random(input int n, input int span);
    int cx, cy;
    for (int i = 0; i < n; i++) begin
      cx = (int'(seg_ax) + int'(seg_bx)) / 512;
      cy = (int'(seg_ay) + int'(seg_by)) / 512;
      if ($urandom_range(9) == 0)
        send_pixel(PIX_W'($urandom), PIX_W'($urandom));
      else
        send_pixel(PIX_W'(cx + int'($urandom_range(2 * span)) - span),
                   PIX_W'(cy + int'($urandom_range(2 * span)) - span));
    end
  endtask

  always @(posedge clk) begin
    pixel_shade_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (rst_n && out_item.valid && out_item.ready) begin
      if (shade_queue.size() == 0)
        report_mismatch("unexpected result", out_item.distance, 0);
      else begin
        want = shade_queue.pop_front();
        if (out_item.distance !== want.distance)
          report_mismatch("distance", out_item.distance, want.distance);
        if (out_item.inside_res !== want.inside_res)
          report_mismatch("inside_res", out_item.inside_res, want.inside_res);
        if (out_item.coverage !== want.coverage)
          report_mismatch("coverage", out_item.coverage, want.coverage);
      end
    end
    out_item.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic test_directed();
    set_segment(0, 0, 0, 0, 0);
    send_pixel(0, 0);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(3, 4);
    set_segment(256, 256, 2560, 256, 0);
    send_pixel(0, 1);
    send_pixel(1, 1);
    send_pixel(5, 1);
    send_pixel(5, 2);
    send_pixel(10, 1);
    send_pixel(12, 3);
    send_pixel(5, 0);
    set_segment(-8388608, -8388608, 8388607, 8388607, 1048575);
    send_pixel(16'hFFFF, 0);
    send_pixel(0, 16'hFFFF);
    send_pixel(16'h5555, 16'hAAAA);
    set_segment(8388607, -8388608, -8388608, 8388607, 128);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(0, 0);
    set_segment(100, 200, 1000, 3000, 300);
    send_pixel(2, 6);
    send_pixel(3, 7);
    wait_drained();
    write_reg(REG_NONE, 24'hFFFFFF);
    send_pixel(4, 8);
  endtask

  task automatic test_random_segments(input int rounds, input int per_round);
    int ax, ay, bx, by, hw, span;
    for (int r = 0; r < rounds; r++) begin
      ax = $urandom_range(16384) - 128;
      ay = $urandom_range(16384) - 128;
      bx = ($urandom_range(3) == 0) ? ax : ax + int'($urandom_range(8192)) - 4096;
      by = ($urandom_range(3) == 0) ? ay : ay + int'($urandom_range(8192)) - 4096;
      hw = ($urandom_range(4) == 0) ? int'($urandom_range(1048575)) : int'($urandom_range(1024));
      if (r % 17 == 16) begin
        ax = $urandom; ay = $urandom; bx = $urandom; by = $urandom;
        ax = ax >>> 8; ay = ay >>> 8; bx = bx >>> 8; by = by >>> 8;
      end
      span = 4 + int'($urandom_range(24));
      set_segment(ax, ay, bx, by, hw);
      send_random(per_round, span);
    end
  endtask

  task automatic test_idle_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random_segments(8, 48);
    send_idle_pct = 79; recv_stall_pct = 0;  test_random_segments(6, 48);
    send_idle_pct = 0;  recv_stall_pct = 79; test_random_segments(6, 48);
    send_idle_pct = 9;  recv_stall_pct = 9;  test_random_segments(6, 48);
    send_idle_pct = 0;  recv_stall_pct = 0;
  endtask

  initial begin
    err_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    seg_ax = '0; seg_ay = '0; seg_bx = '0; seg_by = '0; seg_half_w = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_idle_phases();
    wait_drained();
    repeat (PIPE_LATENCY + 20) @(posedge clk);
    if (err_count == 0 && shade_queue.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
